FILE: sv/slist_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared sizes, command and status codes, and the word broadcast along the
// chain of cells.
// ----------------------------------------------------------------------------
package slist_pkg;

  localparam int Capacity  = 64;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int PosW      = 7;
  localparam int SelW      = (IdxW > PosW) ? IdxW : PosW;
  localparam int CmpW      = (CntW > PosW) ? CntW : PosW;
  localparam int GrpSize   = 8;
  localparam int NGrp      = (Capacity + GrpSize - 1) / GrpSize;

  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_KTH    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_RED1,
    S_RED2,
    S_APPLY
  } state_t;

  // Control word seen by every cell
  typedef struct packed {
    logic            cmp_en;
    logic            ins_en;
    logic            rem_en;
    data_t           key;
    logic [SelW-1:0] pos_m1;
    logic [CntW-1:0] count;
  } bcast_t;

endpackage

FILE: sv/slist_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the broadcast key and shifts to or from
// its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module slist_cell (
  input  logic                          clk,
  input  slist_pkg::bcast_t             bc,
  input  logic [slist_pkg::IdxW-1:0]    idx,
  input  logic                          left_lt,
  input  slist_pkg::data_t              left_val,
  input  slist_pkg::data_t              right_val,
  output logic                          lt,
  output logic                          eq_hit,
  output slist_pkg::data_t              val,
  output slist_pkg::data_t              rd
);

  localparam int CntW = slist_pkg::CntW;
  localparam int SelW = slist_pkg::SelW;

  logic valid;
  logic sel;

  // Cell holds a live entry when its index lies below the count
  always_comb begin
    valid = CntW'(idx) < bc.count;
    sel   = valid && (SelW'(idx) == bc.pos_m1);
  end

  // Capture compare flags once per command
  always_ff @(posedge clk) begin
    if (bc.cmp_en) begin
      lt     <= valid && (val < bc.key);
      eq_hit <= valid && (val == bc.key);
      rd     <= sel ? val : '0;
    end
  end

  // Shift right on insert, left on remove; entries below the key stay
  always_ff @(posedge clk) begin
    if (bc.ins_en) begin
      if (!lt) begin
        val <= left_lt ? bc.key : left_val;
      end
    end else if (bc.rem_en) begin
      if (!lt) begin
        val <= right_val;
      end
    end
  end

endmodule

FILE: sv/slist_tree.sv
// ----------------------------------------------------------------------------
// Sorted list reduction tree
// Two registered OR levels over the cell flags: any match, and the word of
// the selected rank.
// ----------------------------------------------------------------------------
module slist_tree (
  input  logic                               clk,
  input  logic [slist_pkg::Capacity-1:0]     eq_vec,
  input  slist_pkg::data_t                   rd_vec [slist_pkg::Capacity],
  output logic                               any_eq,
  output slist_pkg::data_t                   rd_data
);

  localparam int Capacity = slist_pkg::Capacity;
  localparam int GrpSize  = slist_pkg::GrpSize;
  localparam int NGrp     = slist_pkg::NGrp;

  logic [NGrp-1:0]  grp_eq;
  logic [NGrp-1:0]  grp_eq_next;
  slist_pkg::data_t grp_rd      [NGrp];
  slist_pkg::data_t grp_rd_next [NGrp];
  logic             any_eq_next;
  slist_pkg::data_t rd_data_next;

  // First level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_eq_next[g] = 1'b0;
      grp_rd_next[g] = '0;
      for (int j = 0; j < GrpSize; j++) begin
        if (g * GrpSize + j < Capacity) begin
          grp_eq_next[g] = grp_eq_next[g] | eq_vec[g * GrpSize + j];
          grp_rd_next[g] = grp_rd_next[g] | rd_vec[g * GrpSize + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_eq <= grp_eq_next;
    grp_rd <= grp_rd_next;
  end

  // Second level: OR across groups
  always_comb begin
    any_eq_next  = |grp_eq;
    rd_data_next = '0;
    for (int g = 0; g < NGrp; g++) begin
      rd_data_next = rd_data_next | grp_rd[g];
    end
  end

  always_ff @(posedge clk) begin
    any_eq  <= any_eq_next;
    rd_data <= rd_data_next;
  end

endmodule

FILE: sv/sorted_list_engine_unit.sv
// Each accepted word passes through compare, two reduction levels and
//   apply before its result word; no new word is taken until idle again.
// The registered OR tree gathers match and rank data from the chain of
//   cells before the chain shifts.
// Reset clears the count, state and output valid; cell contents stay
//   undefined and are never observed until written.
// ----------------------------------------------------------------------------
// Sorted list engine
// Ascending store of up to Capacity values in a chain of shifting cells,
// with insert, remove, lookup, rank read and clear commands.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [31:0] value,
  input  logic [6:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] value_out,
  output logic [6:0]  count,
  output logic [1:0]  status
);

  localparam int Capacity  = slist_pkg::Capacity;
  localparam int DataWidth = slist_pkg::DataWidth;
  localparam int IdxW      = slist_pkg::IdxW;
  localparam int CntW      = slist_pkg::CntW;
  localparam int SelW      = slist_pkg::SelW;
  localparam int CmpW      = slist_pkg::CmpW;

  slist_pkg::state_t state, state_next;
  slist_pkg::bcast_t bc;

  logic [2:0]       cmd_q;
  slist_pkg::data_t key_q;
  logic [6:0]       pos_q;
  logic [CntW-1:0]  entry_count, entry_count_next;

  logic             in_take;
  logic             adv;
  logic             ins_go, rem_go;
  logic             found_next;
  slist_pkg::data_t vout_next;
  logic [1:0]       status_next;

  logic [Capacity-1:0] lt_vec;
  logic [Capacity-1:0] eq_vec;
  slist_pkg::data_t    val_vec [Capacity];
  slist_pkg::data_t    rd_vec  [Capacity];
  logic                any_eq;
  slist_pkg::data_t    rd_data;

  assign in_stall = (state != slist_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign adv      = (state == slist_pkg::S_APPLY) && (!out_valid || !out_stall);

  // Hold the command word for the whole sequence
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q <= cmd;
      key_q <= value[DataWidth-1:0];
      pos_q <= position;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next       = state;
    ins_go           = 1'b0;
    rem_go           = 1'b0;
    found_next       = 1'b0;
    vout_next        = '0;
    status_next      = slist_pkg::STAT_OK;
    entry_count_next = entry_count;

    case (state)
      slist_pkg::S_IDLE:  if (in_take) state_next = slist_pkg::S_CMP;
      slist_pkg::S_CMP:   state_next = slist_pkg::S_RED1;
      slist_pkg::S_RED1:  state_next = slist_pkg::S_RED2;
      slist_pkg::S_RED2:  state_next = slist_pkg::S_APPLY;
      slist_pkg::S_APPLY: if (adv) state_next = slist_pkg::S_IDLE;
      default:            state_next = slist_pkg::S_IDLE;
    endcase

    case (cmd_q)
      slist_pkg::CMD_INSERT: begin
        if (entry_count == CntW'(Capacity)) begin
          status_next = slist_pkg::STAT_FULL;
        end else begin
          ins_go           = 1'b1;
          entry_count_next = entry_count + CntW'(1);
        end
      end
      slist_pkg::CMD_REMOVE: begin
        if (any_eq) begin
          rem_go           = 1'b1;
          entry_count_next = entry_count - CntW'(1);
        end else begin
          status_next = slist_pkg::STAT_NOT_FOUND;
        end
      end
      slist_pkg::CMD_LOOKUP: found_next = any_eq;
      slist_pkg::CMD_KTH: begin
        if (pos_q != 7'd0 && CmpW'(pos_q) <= CmpW'(entry_count)) begin
          vout_next = rd_data;
        end else begin
          status_next = slist_pkg::STAT_RANGE;
        end
      end
      slist_pkg::CMD_CLEAR: entry_count_next = '0;
      default: ;
    endcase
  end

  // Broadcast word for the chain
  always_comb begin
    bc.cmp_en = (state == slist_pkg::S_CMP);
    bc.ins_en = adv && ins_go;
    bc.rem_en = adv && rem_go;
    bc.key    = key_q;
    bc.pos_m1 = SelW'(pos_q) - SelW'(1);
    bc.count  = entry_count;
  end

  // Advance the count when the command lands
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (adv) begin
      entry_count <= entry_count_next;
    end
  end

  // Chain of cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic             left_lt;
    slist_pkg::data_t left_val;
    slist_pkg::data_t right_val;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_val = '0;
    end else begin : g_body
      assign left_lt  = lt_vec[i-1];
      assign left_val = val_vec[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign right_val = val_vec[i];
    end else begin : g_mid
      assign right_val = val_vec[i+1];
    end

    slist_cell u_cell (
      .clk       (clk),
      .bc        (bc),
      .idx       (IdxW'(i)),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (lt_vec[i]),
      .eq_hit    (eq_vec[i]),
      .val       (val_vec[i]),
      .rd        (rd_vec[i])
    );
  end

  slist_tree u_tree (
    .clk     (clk),
    .eq_vec  (eq_vec),
    .rd_vec  (rd_vec),
    .any_eq  (any_eq),
    .rd_data (rd_data)
  );

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found     <= found_next;
      value_out <= 32'(vout_next);
      count     <= 7'(entry_count_next);
      status    <= status_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == slist_pkg::S_CMP)
    else $error("accepted word did not start compare");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == slist_pkg::S_APPLY)
    else $error("result word raised outside apply");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    bc.ins_en |=> entry_count == $past(entry_count) + CntW'(1))
    else $error("insert did not grow the count");

endmodule
